@@ hw/rtl/sorted_table_binary_search_macros.svh @@
// Assertion macros for the sorted table search block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
`define STBS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stbs: same-cycle check failed");
`define STBS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stbs: next-cycle check failed");
`else
`define STBS_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define STBS_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/stbs_pkg.sv @@
// Shared types, field layout and microcode ROM for the sorted table search.
// No dependencies.
package stbs_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	// input tdata layout, lowest bit first
	localparam int SLOT_W   = 10;
	localparam int VAL_W    = 32;
	localparam int LOW_W    = 10;
	localparam int HIGH_W   = 11;
	localparam int SLOT_LSB = 0;
	localparam int LVAL_LSB = SLOT_LSB + SLOT_W;
	localparam int TGT_LSB  = LVAL_LSB + VAL_W;
	localparam int LOW_LSB  = TGT_LSB + VAL_W;
	localparam int HIGH_LSB = LOW_LSB + LOW_W;
	localparam int IN_BITS  = HIGH_LSB + HIGH_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	localparam int POS_W       = 10;
	localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;

	// microprogram addresses
	typedef logic [1:0] upc_t;
	localparam upc_t UPC_FETCH  = 2'd0;
	localparam upc_t UPC_CHECK  = 2'd1;
	localparam upc_t UPC_WAIT   = 2'd2;
	localparam upc_t UPC_REPORT = 2'd3;

	// jump conditions
	typedef logic [2:0] cond_t;
	localparam cond_t COND_NEVER    = 3'd0;
	localparam cond_t COND_SEARCH   = 3'd1;
	localparam cond_t COND_EMPTY    = 3'd2;
	localparam cond_t COND_MATCH    = 3'd3;
	localparam cond_t COND_OUT_FREE = 3'd4;

	typedef struct packed {
		logic  in_rdy;  // take an input transaction
		logic  rd_en;   // register midpoint, read table
		logic  cmp;     // narrow range from compare
		logic  emit;    // load output register
		cond_t cond;
		upc_t  jump;    // taken when cond holds
		upc_t  next;
	} uword_t;

	function automatic uword_t ucode_rom(upc_t a);
		uword_t w;
		w = '0;
		case (a)
			UPC_FETCH: begin
				w.in_rdy = 1'b1;
				w.cond   = COND_SEARCH;
				w.jump   = UPC_CHECK;
				w.next   = UPC_FETCH;
			end
			UPC_CHECK: begin
				w.rd_en = 1'b1;
				w.cond  = COND_EMPTY;
				w.jump  = UPC_REPORT;
				w.next  = UPC_WAIT;
			end
			UPC_WAIT: begin
				w.cmp  = 1'b1;
				w.cond = COND_MATCH;
				w.jump = UPC_REPORT;
				w.next = UPC_CHECK;
			end
			UPC_REPORT: begin
				w.emit = 1'b1;
				w.cond = COND_OUT_FREE;
				w.jump = UPC_FETCH;
				w.next = UPC_REPORT;
			end
			default: begin
				w.cond = COND_NEVER;
				w.next = UPC_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/sorted_table_binary_search.sv @@
// Sorted table binary search, microcoded sequencer over one table RAM.
// Load transaction: table written at the accept edge.
// Search transaction: each probe is a RAM read (CHECK) then a compare (WAIT); a
// 1024-entry table needs at most 11 probes before the result is reported.
// Next input is taken only after the search result is loaded into the output register.
// arst_n clears sequencer and output valid; table contents are not reset.
`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search import stbs_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// slot, load_value, target, search_low, search_high, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// kind
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// position, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// found
	output logic                   m_axis_tuser
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int RW = ((AW > HIGH_W) ? AW : HIGH_W) + 2;
	localparam logic signed [RW-1:0] LAST_SLOT = RW'(TABLE_DEPTH - 1);

	logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

	upc_t   upc_q;
	uword_t uw;
	logic   cond_hit;

	logic                       in_acc;
	logic                       kind_in;
	logic [SLOT_W-1:0]          slot_in;
	logic signed [VAL_W-1:0]    lval_in;
	logic signed [VAL_W-1:0]    tgt_in;
	logic [LOW_W-1:0]           low_in;
	logic signed [HIGH_W-1:0]   high_in;
	logic signed [RW-1:0]       high_ext;
	logic                       wr_en;

	logic signed [RW-1:0]          lo_q, hi_q, mid_q, mid_c;
	logic signed [VALUE_WIDTH-1:0] tgt_q, rd_q;
	logic                          found_q;
	logic [AW-1:0]                 pos_q;
	logic                          out_free;
	logic                          m_found_q;
	logic [POS_W-1:0]              m_pos_q;

	assign uw = ucode_rom(upc_q);

	assign kind_in = s_axis_tuser;
	assign slot_in = s_axis_tdata[SLOT_LSB +: SLOT_W];
	assign lval_in = s_axis_tdata[LVAL_LSB +: VAL_W];
	assign tgt_in  = s_axis_tdata[TGT_LSB +: VAL_W];
	assign low_in  = s_axis_tdata[LOW_LSB +: LOW_W];
	assign high_in = s_axis_tdata[HIGH_LSB +: HIGH_W];

	assign s_axis_tready = uw.in_rdy;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign wr_en         = in_acc && !kind_in && (32'(slot_in) < 32'(TABLE_DEPTH));
	assign high_ext      = RW'(high_in);
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	// range is non-empty whenever a probe's midpoint is compared, so the shift is exact there
	assign mid_c = lo_q + ((hi_q - lo_q) >>> 1);

	always_comb begin
		case (uw.cond)
			COND_SEARCH:   cond_hit = in_acc && kind_in;
			COND_EMPTY:    cond_hit = lo_q > hi_q;
			COND_MATCH:    cond_hit = rd_q == tgt_q;
			COND_OUT_FREE: cond_hit = out_free;
			default:       cond_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q         <= UPC_FETCH;
			m_axis_tvalid <= 1'b0;
		end else begin
			upc_q <= cond_hit ? uw.jump : uw.next;
			if (uw.emit && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// table RAM: one write port (loads), one registered read port (probes)
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(slot_in)] <= VALUE_WIDTH'(lval_in);
		end
		if (uw.rd_en) begin
			rd_q <= mem[mid_c[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && kind_in) begin
			lo_q    <= RW'(low_in);
			hi_q    <= (high_ext > LAST_SLOT) ? LAST_SLOT : high_ext;
			tgt_q   <= VALUE_WIDTH'(tgt_in);
			found_q <= 1'b0;
			pos_q   <= '0;
		end
		if (uw.rd_en) begin
			mid_q <= mid_c;
		end
		if (uw.cmp) begin
			if (rd_q < tgt_q) begin
				lo_q <= mid_q + RW'(1);
			end else if (rd_q > tgt_q) begin
				hi_q <= mid_q - RW'(1);
			end else begin
				found_q <= 1'b1;
				pos_q   <= mid_q[AW-1:0];
			end
		end
		if (uw.emit && out_free) begin
			m_found_q <= found_q;
			m_pos_q   <= POS_W'(pos_q);
		end
	end

	assign m_axis_tuser = m_found_q;
	assign m_axis_tdata = OUT_TDATA_W'(m_pos_q);

	`STBS_ASSERT_NXT(a_search_start, clk, arst_n, in_acc && kind_in, (upc_q == UPC_CHECK) && !found_q)
	`STBS_ASSERT_NXT(a_step_up, clk, arst_n, (upc_q == UPC_WAIT) && (rd_q < tgt_q), lo_q == $past(mid_q) + RW'(1))
	`STBS_ASSERT_IMP(a_miss_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)

endmodule
